[rtl/core/sfts_pkg.sv]
`default_nettype none

package sfts_pkg;

   // datapath operations issued by the sequencer
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_FLT,
      OP_KELV,
      OP_SQ,
      OP_Q,
      OP_X1,
      OP_X2,
      OP_X3,
      OP_RAD,
      OP_H1,
      OP_H2,
      OP_C1,
      OP_K,
      OP_ALQ,
      OP_M1,
      OP_M2,
      OP_M3,
      OP_DIVI,
      OP_UPD,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic       fault;
      logic [1:0] mode;
      logic       div_last;
   } status_type;

   // csr register indexes
   typedef enum logic [2:0] {
      CSR_MODE,
      CSR_EMISSIVITY,
      CSR_INS_COND,
      CSR_PROT_CAP,
      CSR_COAT_RES,
      CSR_SECTION,
      CSR_STEEL_CAP,
      CSR_TIME_STEP
   } csr_index_type;

   // protection modes
   localparam logic [1:0] MODE_UNPROT = 2'd0;
   localparam logic [1:0] MODE_HEAVY  = 2'd1;
   localparam logic [1:0] MODE_COAT   = 2'd2;
   localparam logic [1:0] MODE_LIGHT  = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [23:0] SIGMA_Q48    = 24'd15959631;
   localparam int          KELVIN_C     = 273;
   localparam int          CONV_COEF    = 25;
   localparam int          START_C      = 20;
   localparam int          ALPHA_W      = 26;
   localparam int          DIV_W        = 64;
   localparam int          DEN_W        = 41;

endpackage

`default_nettype wire

[rtl/core/sfts_datapath.sv]
`default_nettype none

module sfts_datapath #(
   parameter int TEMP_FRAC_BITS = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [sfts_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [sfts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic signed [15:0]               req_gas_temp,
   input  wire logic                             req_restart,
   input  wire sfts_pkg::cmd_type                cmd,
   output sfts_pkg::status_type                  status,
   output logic signed [15:0]                    rsp_steel_temp,
   output logic                                  rsp_saturated,
   output logic                                  rsp_config_fault
);
   import sfts_pkg::*;

   localparam int KOFF  = KELVIN_C << TEMP_FRAC_BITS;
   localparam int KW    = $clog2(32767 + KOFF + 1);
   localparam int SW    = KW + 1;
   localparam int SQW   = 2 * KW + 1;
   localparam int QW    = SQW - TEMP_FRAC_BITS;
   localparam int SQPW  = SW + QW;
   localparam int XW    = SQPW + 16;
   localparam int RADSH = 2 * TEMP_FRAC_BITS + 32;
   localparam int RADW  = XW - RADSH + 1;
   localparam logic signed [15:0] START_TEMP = 16'(START_C << TEMP_FRAC_BITS);

   function automatic logic [ALPHA_W-1:0] cap_alpha(input logic [DIV_W-1:0] v);
      cap_alpha = (|v[DIV_W-1:ALPHA_W]) ? '1 : v[ALPHA_W-1:0];
   endfunction

   // configuration registers
   logic [1:0]  mode_ff;
   logic [15:0] eps_ff;
   logic [23:0] kcond_ff;
   logic [23:0] pcap_ff;
   logic [23:0] cres_ff;
   logic [15:0] sfac_ff;
   logic [24:0] scap_ff;
   logic [5:0]  tstep_ff;

   // working registers
   logic signed [15:0]  ts_ff;
   logic signed [15:0]  tg_ff;
   logic [KW-1:0]       a_ff, b_ff;
   logic [2*KW-1:0]     aa_ff, bb_ff;
   logic [SW-1:0]       s_ff;
   logic [QW-1:0]       q_ff;
   logic [XW-1:0]       p_ff;
   logic [ALPHA_W-1:0]  alpha_ff;
   logic [39:0]         t_ff;
   logic [DIV_W-1:0]    num_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [DEN_W-1:0]    rem_ff;
   logic [5:0]          cnt_ff;
   logic [47:0]         m_ff;
   logic [16:0]         mag_ff;
   logic                neg_ff;
   logic                sat_ff;
   logic                fault_ff;

   // combinational helpers
   logic signed [KW+1:0] tgk, tsk;
   logic [2*KW-1:0]      aa_in, bb_in;
   logic [SQW-1:0]       sumsq;
   logic [SQPW-1:0]      sq_prod;
   logic [XW-1:0]        pe_prod;
   logic [XW-1:0]        ps_prod;
   logic [RADW-1:0]      rad_val;
   logic [29:0]          c32;
   logic [53:0]          kc_prod;
   logic [39:0]          pf_prod;
   logic [41:0]          af_prod;
   logic [47:0]          md_prod;
   logic [64:0]          mm_prod;
   logic signed [16:0]   diff;
   logic [DEN_W:0]       rem_sh;
   logic                 ge;
   logic signed [18:0]   ts19, inc19, sum19;
   logic                 ovf;
   logic signed [15:0]   nt;

   // kelvin conversion, clamped at absolute zero
   assign tgk = (KW+2)'(tg_ff) + (KW+2)'(KOFF);
   assign tsk = (KW+2)'(ts_ff) + (KW+2)'(KOFF);

   assign aa_in   = a_ff * a_ff;
   assign bb_in   = b_ff * b_ff;
   assign sumsq   = SQW'(aa_ff) + SQW'(bb_ff);
   assign sq_prod = s_ff * q_ff;
   assign pe_prod = p_ff[SQPW-1:0] * eps_ff;
   assign ps_prod = p_ff[XW-1:24] * SIGMA_Q48;
   assign rad_val = RADW'(p_ff[XW-1:RADSH]) + RADW'(CONV_COEF << 8);

   assign c32     = {scap_ff, 5'b0};
   assign kc_prod = kcond_ff * c32;
   assign pf_prod = pcap_ff * sfac_ff;
   assign af_prod = alpha_ff * sfac_ff;
   assign md_prod = m_ff[41:0] * tstep_ff;
   assign mm_prod = m_ff * mag_ff;

   assign diff = {tg_ff[15], tg_ff} - {ts_ff[15], ts_ff};

   // restoring divider step
   assign rem_sh = {rem_ff, num_ff[DIV_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   // apply the increment and clamp
   assign ts19  = {{3{ts_ff[15]}}, ts_ff};
   assign inc19 = {2'b0, num_ff[16:0]};
   assign sum19 = neg_ff ? ts19 - inc19 : ts19 + inc19;
   assign ovf   = (|num_ff[DIV_W-1:17]) || (sum19[18:15] != {4{sum19[18]}});
   assign nt    = ovf ? (neg_ff ? 16'sh8000 : 16'sh7FFF) : sum19[15:0];

   assign status.fault    = (sfac_ff == '0) || (scap_ff == '0);
   assign status.mode     = mode_ff;
   assign status.div_last = (cnt_ff == 6'd63);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_UNPROT;
         eps_ff   <= 16'd45875;
         kcond_ff <= '0;
         pcap_ff  <= '0;
         cres_ff  <= 24'd65536;
         sfac_ff  <= 16'd3200;
         scap_ff  <= 25'd4710000;
         tstep_ff <= 6'd5;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_MODE:       mode_ff  <= csr_wdata[1:0];
            CSR_EMISSIVITY: eps_ff   <= csr_wdata[15:0];
            CSR_INS_COND:   kcond_ff <= csr_wdata[23:0];
            CSR_PROT_CAP:   pcap_ff  <= csr_wdata[23:0];
            CSR_COAT_RES:   cres_ff  <= csr_wdata[23:0];
            CSR_SECTION:    sfac_ff  <= csr_wdata[15:0];
            CSR_STEEL_CAP:  scap_ff  <= csr_wdata[24:0];
            CSR_TIME_STEP:  tstep_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // steel temperature state
   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff <= START_TEMP;
      end else if (cmd.op == OP_LOAD && req_restart) begin
         ts_ff <= START_TEMP;
      end else if (cmd.op == OP_UPD) begin
         ts_ff <= nt;
      end
   end

   // working datapath
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: tg_ff <= req_gas_temp;
         OP_FLT: begin
            sat_ff   <= 1'b0;
            fault_ff <= 1'b1;
         end
         OP_KELV: begin
            a_ff <= tgk[KW+1] ? '0 : tgk[KW-1:0];
            b_ff <= tsk[KW+1] ? '0 : tsk[KW-1:0];
         end
         OP_SQ: begin
            aa_ff <= aa_in;
            bb_ff <= bb_in;
            s_ff  <= SW'(a_ff) + SW'(b_ff);
         end
         OP_Q:   q_ff <= sumsq[SQW-1:TEMP_FRAC_BITS];
         OP_X1:  p_ff <= XW'(sq_prod);
         OP_X2:  p_ff <= pe_prod;
         OP_X3:  p_ff <= ps_prod;
         OP_RAD: alpha_ff <= cap_alpha(DIV_W'(rad_val));
         OP_H1: begin
            num_ff <= DIV_W'(kc_prod);
            t_ff   <= pf_prod;
         end
         OP_H2: begin
            den_ff <= DEN_W'(c32) + DEN_W'(t_ff);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_C1: begin
            num_ff <= DIV_W'(1) << 24;
            den_ff <= (cres_ff == '0) ? DEN_W'(1) : DEN_W'(cres_ff);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_K:   alpha_ff <= ALPHA_W'(kcond_ff);
         OP_ALQ: alpha_ff <= cap_alpha(num_ff);
         OP_M1: begin
            m_ff   <= 48'(af_prod);
            neg_ff <= diff[16];
            mag_ff <= diff[16] ? 17'(-diff) : 17'(diff);
         end
         OP_M2: m_ff <= md_prod;
         OP_M3: begin
            num_ff <= mm_prod[DIV_W-1:0];
            den_ff <= DEN_W'({scap_ff, 12'b0});
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_DIVI: begin
            rem_ff <= ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            num_ff <= {num_ff[DIV_W-2:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
         end
         OP_UPD: begin
            sat_ff   <= ovf;
            fault_ff <= 1'b0;
         end
         OP_OUT: begin
            rsp_steel_temp   <= ts_ff;
            rsp_saturated    <= sat_ff;
            rsp_config_fault <= fault_ff;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/sfts_ctrl.sv]
`default_nettype none

module sfts_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire sfts_pkg::status_type status,
   output sfts_pkg::cmd_type         cmd
);
   import sfts_pkg::*;

   typedef enum logic [20:0] {
      S_IDLE = 21'(1 << 0),
      S_SEL  = 21'(1 << 1),
      S_FLT  = 21'(1 << 2),
      S_KELV = 21'(1 << 3),
      S_SQ   = 21'(1 << 4),
      S_Q    = 21'(1 << 5),
      S_X1   = 21'(1 << 6),
      S_X2   = 21'(1 << 7),
      S_X3   = 21'(1 << 8),
      S_RAD  = 21'(1 << 9),
      S_H1   = 21'(1 << 10),
      S_H2   = 21'(1 << 11),
      S_C1   = 21'(1 << 12),
      S_K    = 21'(1 << 13),
      S_ALQ  = 21'(1 << 14),
      S_M1   = 21'(1 << 15),
      S_M2   = 21'(1 << 16),
      S_M3   = 21'(1 << 17),
      S_DIVI = 21'(1 << 18),
      S_UPD  = 21'(1 << 19),
      S_OUT  = 21'(1 << 20)
   } state_type;

   state_type state_ff, state_in;
   logic      final_ff, final_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            if (status.fault) begin
               state_in = S_FLT;
            end else begin
               case (status.mode)
                  MODE_UNPROT: state_in = S_KELV;
                  MODE_HEAVY:  state_in = S_H1;
                  MODE_COAT:   state_in = S_C1;
                  default:     state_in = S_K;
               endcase
            end
         end
         S_FLT: begin
            cmd.op   = OP_FLT;
            state_in = S_OUT;
         end
         S_KELV: begin cmd.op = OP_KELV; state_in = S_SQ;  end
         S_SQ:   begin cmd.op = OP_SQ;   state_in = S_Q;   end
         S_Q:    begin cmd.op = OP_Q;    state_in = S_X1;  end
         S_X1:   begin cmd.op = OP_X1;   state_in = S_X2;  end
         S_X2:   begin cmd.op = OP_X2;   state_in = S_X3;  end
         S_X3:   begin cmd.op = OP_X3;   state_in = S_RAD; end
         S_RAD:  begin cmd.op = OP_RAD;  state_in = S_M1;  end
         S_H1:   begin cmd.op = OP_H1;   state_in = S_H2;  end
         S_H2: begin
            cmd.op   = OP_H2;
            final_in = 1'b0;
            state_in = S_DIVI;
         end
         S_C1: begin
            cmd.op   = OP_C1;
            final_in = 1'b0;
            state_in = S_DIVI;
         end
         S_K:    begin cmd.op = OP_K;    state_in = S_M1;  end
         S_ALQ:  begin cmd.op = OP_ALQ;  state_in = S_M1;  end
         S_M1:   begin cmd.op = OP_M1;   state_in = S_M2;  end
         S_M2:   begin cmd.op = OP_M2;   state_in = S_M3;  end
         S_M3: begin
            cmd.op   = OP_M3;
            final_in = 1'b1;
            state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.op = OP_DIVI;
            if (status.div_last) begin
               state_in = final_ff ? S_UPD : S_ALQ;
            end
         end
         S_UPD: begin cmd.op = OP_UPD; state_in = S_OUT; end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/steel_fire_temperature_step_top.sv]
// one item at a time: a new input beat is taken only after the result beat of the last
//    item is issued; the 64-step restoring divider runs once per item (unprotected, light
//    insulation), or twice where alpha itself is a quotient (coating, heavy insulation),
//    and not at all on a config fault; a result beat still waiting holds back the next one
// reset: synchronous, active high; config and control registers take their defaults, steel at 20 C
`default_nettype none

module steel_fire_temperature_step_top #(
   parameter int TEMP_FRAC_BITS = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [sfts_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [sfts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [15:0]               req_gas_temp,
   input  wire logic                             req_restart,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [15:0]                    rsp_steel_temp,
   output logic                                  rsp_saturated,
   output logic                                  rsp_config_fault
);
   import sfts_pkg::*;

   cmd_type    cmd;
   status_type status;

   sfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfts_datapath #(
      .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_gas_temp     (req_gas_temp),
      .req_restart      (req_restart),
      .cmd              (cmd),
      .status           (status),
      .rsp_steel_temp   (rsp_steel_temp),
      .rsp_saturated    (rsp_saturated),
      .rsp_config_fault (rsp_config_fault)
   );

endmodule

`default_nettype wire

[rtl/core/sfts_checker.sv]
`default_nettype none

module sfts_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             csr_wr_en,
   input wire logic [sfts_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input wire logic [sfts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic signed [15:0]               req_gas_temp,
   input wire logic                             req_restart,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic signed [15:0]               rsp_steel_temp,
   input wire logic                             rsp_saturated,
   input wire logic                             rsp_config_fault
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item in flight: busy after an input beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // a faulted step never reports clamping
   a_fault_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_fault |-> !rsp_saturated)
      else $error("fault and saturation together");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_steel_temp))
      else $error("result beat changed while stalled");

endmodule

bind steel_fire_temperature_step_top sfts_checker u_sfts_checker (.*);

`default_nettype wire
